/* rtl/core/assert_macros.svh */
// assertion helpers used by threshold_purge_fifo
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check, disabled while reset is low
`define TPF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication check, disabled while reset is low
`define TPF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* rtl/core/tpf_pkg.sv */
package tpf_pkg;

    // queue geometry
    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // field widths
    localparam int ID_W    = 31;
    localparam int SCORE_W = 12;
    localparam int CMD_W   = 2;
    localparam int KIND_W  = 3;
    localparam int REM_W   = 5;

    localparam logic [SCORE_W-1:0] THR_RESET = SCORE_W'(2500);

    // command codes
    localparam logic [CMD_W-1:0] CMD_ENQ   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEQ   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PURGE = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] K_ENQ     = 3'd0;
    localparam logic [KIND_W-1:0] K_FULL    = 3'd1;
    localparam logic [KIND_W-1:0] K_DEQ     = 3'd2;
    localparam logic [KIND_W-1:0] K_EMPTY   = 3'd3;
    localparam logic [KIND_W-1:0] K_REMOVED = 3'd4;
    localparam logic [KIND_W-1:0] K_DONE    = 3'd5;

    // one stored record
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [SCORE_W-1:0] score;
    } t_rec;

    // per-cycle control broadcast to every cell
    typedef struct packed {
        logic enq;    // load the input record at the tail slot
        logic shift;  // each cell takes its neighbor's record; the last cell keeps its own
        logic rot;    // during a shift, the head record lands at the tail slot
    } t_cell_ctl;

    // number of set bits in a cell-wide flag vector
    function automatic logic [CNT_W-1:0] popcount(input logic [DEPTH-1:0] v);
        logic [CNT_W-1:0] s;
        s = '0;
        for (int i = 0; i < DEPTH; i++) begin
            s = s + CNT_W'(v[i]);
        end
        return s;
    endfunction

endpackage

/* rtl/core/tpf_cell.sv */
module tpf_cell (
    input  logic                          i_clk,
    input  tpf_pkg::t_cell_ctl            i_ctl,
    input  logic                          i_at_end,
    input  tpf_pkg::t_rec                 i_next,
    input  tpf_pkg::t_rec                 i_head,
    input  tpf_pkg::t_rec                 i_in,
    input  logic [tpf_pkg::SCORE_W-1:0]   i_thr,
    output tpf_pkg::t_rec                 o_rec,
    output logic                          o_keep
);

    tpf_pkg::t_rec r_rec;
    tpf_pkg::t_rec n_rec;

    // next record: shift from neighbor, take rotated head, or load new record
    always_comb begin
        n_rec = r_rec;
        if (i_ctl.shift) begin
            n_rec = (i_ctl.rot && i_at_end) ? i_head : i_next;
        end else if (i_ctl.enq && i_at_end) begin
            n_rec = i_in;
        end
    end

    // record storage, no reset needed
    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

    assign o_rec  = r_rec;
    assign o_keep = (r_rec.score >= i_thr);

endmodule

/* rtl/core/threshold_purge_fifo.sv */
// threshold_purge_fifo: bounded queue of records (id, score in hundredths)
// held in a row of cells, head in cell 0.
// input stream: tuser = command (enqueue, dequeue, purge), tdata = record.
// output stream: tuser = result kind, tdata = id, score, remaining count,
// tlast marks the final beat of a command.
// config: i_cfg_we writes the purge threshold (reset value 2500).
// enqueue and dequeue give one beat each; the result is registered and
// shows in the cycle after the input beat, and one command per cycle is taken
// as long as the output register drains.
// purge steps through count, walk and done states: it counts survivors,
// walks each stored record through the cell chain, sees the walk end and
// loads the done beat; removed beats go out during the walk. Input is held
// off (tready low) until the done beat is out.
// a stalled receiver holds the output register and pauses the walk on the
// next removed record; kept records rotate on regardless.
// reset (synchronous, active low) empties the queue and restores the
// threshold; cell contents are not cleared.
`include "assert_macros.svh"

module threshold_purge_fifo (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config port
    input  logic        i_cfg_we,
    input  logic [11:0] i_cfg_wdata,      // score_threshold
    // command stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // student_id[30:0], score[42:31], zero pad
    input  logic [1:0]  i_s_axis_tuser,   // cmd
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // out_id[30:0], out_score[42:31], remaining[47:43]
    output logic [2:0]  o_m_axis_tuser,   // kind
    output logic        o_m_axis_tlast    // last
);

    localparam int DEPTH = tpf_pkg::DEPTH;
    localparam int CNT_W = tpf_pkg::CNT_W;

    typedef enum logic [1:0] {S_IDLE, S_COUNT, S_WALK, S_DONE} t_state;

    t_state                          r_state, n_state;
    logic [CNT_W-1:0]                r_count, n_count;
    logic [CNT_W-1:0]                r_steps, n_steps;
    logic [CNT_W-1:0]                r_kept, n_kept;
    logic [tpf_pkg::SCORE_W-1:0]     r_thr;

    logic                            r_out_valid, n_out_valid;
    logic [tpf_pkg::KIND_W-1:0]      r_kind;
    logic [tpf_pkg::ID_W-1:0]        r_id;
    logic [tpf_pkg::SCORE_W-1:0]     r_score;
    logic [tpf_pkg::REM_W-1:0]       r_rem;
    logic                            r_last;

    logic                            w_free;
    logic                            w_in_acc;
    logic                            w_emit;
    logic [tpf_pkg::KIND_W-1:0]      w_kind;
    logic [tpf_pkg::ID_W-1:0]        w_id;
    logic [tpf_pkg::SCORE_W-1:0]     w_score;
    logic [CNT_W-1:0]                w_rem;
    logic                            w_last;

    tpf_pkg::t_cell_ctl              w_ctl;
    tpf_pkg::t_rec                   w_in_rec;
    tpf_pkg::t_rec                   w_rec   [DEPTH];
    logic [DEPTH-1:0]                w_keep;
    logic [DEPTH-1:0]                w_keep_valid;
    logic [DEPTH-1:0]                w_at_end;

    assign w_in_rec.id    = i_s_axis_tdata[30:0];
    assign w_in_rec.score = i_s_axis_tdata[42:31];

    // output slot free when empty or being drained this cycle
    assign w_free          = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE) && w_free;
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;

    // chain of record cells, cell 0 is the head
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        // tail slot: first free cell for enqueue, last held cell for rotation
        assign w_at_end[g] = w_ctl.enq ? (CNT_W'(g) == r_count)
                                       : (CNT_W'(g) == r_count - CNT_W'(1));
        assign w_keep_valid[g] = w_keep[g] && (CNT_W'(g) < r_count);

        tpf_cell u_cell (
            .i_clk    (i_clk),
            .i_ctl    (w_ctl),
            .i_at_end (w_at_end[g]),
            .i_next   ((g == DEPTH - 1) ? w_rec[g] : w_rec[(g + 1) % DEPTH]),
            .i_head   (w_rec[0]),
            .i_in     (w_in_rec),
            .i_thr    (r_thr),
            .o_rec    (w_rec[g]),
            .o_keep   (w_keep[g])
        );
    end

    // command sequencing and result selection
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_steps = r_steps;
        n_kept  = r_kept;
        w_ctl   = '0;
        w_emit  = 1'b0;
        w_kind  = tpf_pkg::K_ENQ;
        w_id    = '0;
        w_score = '0;
        w_rem   = r_count;
        w_last  = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    unique case (i_s_axis_tuser)
                        tpf_pkg::CMD_ENQ: begin
                            w_emit = 1'b1;
                            if (r_count == CNT_W'(DEPTH)) begin
                                w_kind = tpf_pkg::K_FULL;
                            end else begin
                                w_ctl.enq = 1'b1;
                                n_count   = r_count + CNT_W'(1);
                                w_rem     = n_count;
                            end
                        end
                        tpf_pkg::CMD_DEQ: begin
                            w_emit = 1'b1;
                            if (r_count == '0) begin
                                w_kind = tpf_pkg::K_EMPTY;
                            end else begin
                                w_ctl.shift = 1'b1;
                                w_kind      = tpf_pkg::K_DEQ;
                                w_id        = w_rec[0].id;
                                w_score     = w_rec[0].score;
                                n_count     = r_count - CNT_W'(1);
                                w_rem       = n_count;
                            end
                        end
                        tpf_pkg::CMD_PURGE: begin
                            n_steps = r_count;
                            n_state = S_COUNT;
                        end
                        default: ;
                    endcase
                end
            end
            S_COUNT: begin
                n_kept  = tpf_pkg::popcount(w_keep_valid);
                n_state = S_WALK;
            end
            S_WALK: begin
                if (r_steps == '0) begin
                    n_state = S_DONE;
                end else if (w_keep[0]) begin
                    // survivor goes round to the tail
                    w_ctl.shift = 1'b1;
                    w_ctl.rot   = 1'b1;
                    n_steps     = r_steps - CNT_W'(1);
                end else if (w_free) begin
                    // removed record leaves the chain as a beat
                    w_ctl.shift = 1'b1;
                    w_emit      = 1'b1;
                    w_kind      = tpf_pkg::K_REMOVED;
                    w_id        = w_rec[0].id;
                    w_score     = w_rec[0].score;
                    w_rem       = r_kept;
                    w_last      = 1'b0;
                    n_count     = r_count - CNT_W'(1);
                    n_steps     = r_steps - CNT_W'(1);
                end
            end
            S_DONE: begin
                if (w_free) begin
                    w_emit  = 1'b1;
                    w_kind  = tpf_pkg::K_DONE;
                    w_rem   = r_count;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_out_valid = w_emit || (r_out_valid && !i_m_axis_tready);
    end

    // state, counters, threshold and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_steps     <= '0;
            r_kept      <= '0;
            r_thr       <= tpf_pkg::THR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_steps     <= n_steps;
            r_kept      <= n_kept;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
        end
        if (w_emit) begin
            r_kind  <= w_kind;
            r_id    <= w_id;
            r_score <= w_score;
            r_rem   <= tpf_pkg::REM_W'(w_rem);
            r_last  <= w_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_rem, r_score, r_id};
    assign o_m_axis_tuser  = r_kind;
    assign o_m_axis_tlast  = r_last;

    // checks
    `TPF_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH), "fill count above depth")
    `TPF_ASSERT_IMPL(a_busy_no_ready, i_clk, i_rst_n, r_state != S_IDLE, !o_s_axis_tready, "input taken during purge")
    `TPF_ASSERT_IMPL(a_walk_steps, i_clk, i_rst_n, r_state == S_WALK, r_steps <= r_count, "walk steps exceed held records")
    `TPF_ASSERT_IMPL(a_kept_match, i_clk, i_rst_n, r_state == S_DONE, r_count == r_kept, "survivor count differs from walk result")

endmodule

/* tb/sv/tb_threshold_purge_fifo.sv */
`timescale 1ns / 1ps

module tb_threshold_purge_fifo;
    import tpf_pkg::*;

    // command code the block ignores
    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    // worst purge walk plus margin, used before config writes and at the end
    localparam int SETTLE_CYCLES = 2 * DEPTH + 16;
    localparam int PHASE_BEATS = 46;

    typedef struct {
        logic [CMD_W-1:0]   cmd;
        logic [ID_W-1:0]    id;
        logic [SCORE_W-1:0] score;
    } t_cmd_beat;

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [ID_W-1:0]    id;
        logic [SCORE_W-1:0] score;
        logic [REM_W-1:0]   rem;
        logic               last;
    } t_result_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [11:0] i_cfg_wdata = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [47:0] i_s_axis_tdata = '0;   // student_id[30:0], score[42:31], zero pad
    logic [1:0]  i_s_axis_tuser = '0;   // cmd
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b1;
    logic [47:0] o_m_axis_tdata;        // out_id[30:0], out_score[42:31], remaining[47:43]
    logic [2:0]  o_m_axis_tuser;        // kind
    logic        o_m_axis_tlast;        // last

    threshold_purge_fifo uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // shadow copy of the queue and the threshold
    logic [ID_W-1:0]    shadow_id [DEPTH];
    logic [SCORE_W-1:0] shadow_score [DEPTH];
    int                 shadow_head = 0;
    int                 shadow_tail = 0;
    int                 shadow_fill = 0;
    logic [SCORE_W-1:0] shadow_thr = THR_RESET;

    t_cmd_beat    cmd_backlog[$];
    t_result_beat expected_results[$];
    int           mismatches = 0;
    int           cycle_count = 0;

    // idle draw: random wait length, zero during stretches of no idling
    function automatic int draw_wait(input bit no_idle);
        return no_idle ? 0 : $urandom_range(0, 16);
    endfunction

    function automatic t_result_beat make_result(input logic [KIND_W-1:0] kind,
                                                 input logic [ID_W-1:0] id,
                                                 input logic [SCORE_W-1:0] score,
                                                 input int rem, input logic last);
        t_result_beat r;
        r.kind = kind;
        r.id = id;
        r.score = score;
        r.rem = REM_W'(rem);
        r.last = last;
        return r;
    endfunction

    // advance the shadow queue by one command and queue up its result beats
    task automatic run_command(input t_cmd_beat b);
        int rd;
        int wr;
        int kept;
        t_result_beat removed[$];
        rd = shadow_head;
        wr = shadow_head;
        kept = 0;
        case (b.cmd)
            CMD_ENQ: begin
                if (shadow_fill >= DEPTH) begin
                    expected_results.push_back(make_result(K_FULL, '0, '0, shadow_fill, 1'b1));
                end else begin
                    shadow_id[shadow_tail] = b.id;
                    shadow_score[shadow_tail] = b.score;
                    shadow_tail = (shadow_tail + 1) % DEPTH;
                    shadow_fill++;
                    expected_results.push_back(make_result(K_ENQ, '0, '0, shadow_fill, 1'b1));
                end
            end
            CMD_DEQ: begin
                if (shadow_fill == 0) begin
                    expected_results.push_back(make_result(K_EMPTY, '0, '0, 0, 1'b1));
                end else begin
                    shadow_fill--;
                    expected_results.push_back(make_result(K_DEQ, shadow_id[shadow_head],
                        shadow_score[shadow_head], shadow_fill, 1'b1));
                    shadow_head = (shadow_head + 1) % DEPTH;
                end
            end
            CMD_PURGE: begin
                // compact survivors toward the head, collect the removed ones in order
                for (int i = 0; i < shadow_fill; i++) begin
                    if (shadow_score[rd] < shadow_thr) begin
                        removed.push_back(make_result(K_REMOVED, shadow_id[rd],
                            shadow_score[rd], 0, 1'b0));
                    end else begin
                        shadow_id[wr] = shadow_id[rd];
                        shadow_score[wr] = shadow_score[rd];
                        wr = (wr + 1) % DEPTH;
                        kept++;
                    end
                    rd = (rd + 1) % DEPTH;
                end
                shadow_fill = kept;
                shadow_tail = wr;
                foreach (removed[k]) begin
                    removed[k].rem = REM_W'(kept);
                    expected_results.push_back(removed[k]);
                end
                expected_results.push_back(make_result(K_DONE, '0, '0, kept, 1'b1));
            end
            default: ;
        endcase
    endtask

    // random command; scores cluster around the threshold now and then
    function automatic t_cmd_beat random_command(input int enq_pct, input int purge_pct);
        t_cmd_beat b;
        int roll;
        int near;
        roll = $urandom_range(0, 99);
        if (roll < enq_pct)
            b.cmd = CMD_ENQ;
        else if (roll < enq_pct + purge_pct)
            b.cmd = CMD_PURGE;
        else if (roll < 96)
            b.cmd = CMD_DEQ;
        else
            b.cmd = CMD_NOP;
        b.id = ID_W'($urandom);
        case ($urandom_range(0, 7))
            0: b.score = SCORE_W'($urandom);
            1, 2: begin
                near = int'(shadow_thr) + $urandom_range(0, 4) - 2;
                if (near < 0)
                    near = 0;
                if (near > 4095)
                    near = 4095;
                b.score = SCORE_W'(near);
            end
            default: b.score = SCORE_W'($urandom_range(0, 3100));
        endcase
        return b;
    endfunction

    // command driver
    t_cmd_beat drv_beat;
    int        drv_gap = 0;
    bit        drv_no_idle = 1'b0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                run_command(drv_beat);
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (cmd_backlog.size() > 0) begin
                    drv_beat = cmd_backlog.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tuser <= drv_beat.cmd;
                    i_s_axis_tdata <= {5'b0, drv_beat.score, drv_beat.id};
                    if ($urandom_range(0, 11) == 0)
                        drv_no_idle = !drv_no_idle;
                    drv_gap = draw_wait(drv_no_idle);
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    int mon_wait = 0;
    bit mon_no_idle = 1'b0;

    always @(posedge i_clk) begin : result_check
        t_result_beat got;
        t_result_beat want;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.kind = o_m_axis_tuser;
                got.id = o_m_axis_tdata[30:0];
                got.score = o_m_axis_tdata[42:31];
                got.rem = o_m_axis_tdata[47:43];
                got.last = o_m_axis_tlast;
                if (expected_results.size() == 0) begin
                    $error("unexpected result beat: kind %0d id %0d", got.kind, got.id);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.kind !== want.kind) begin
                        $error("kind mismatch: expected %0d, got %0d", want.kind, got.kind);
                        mismatches++;
                    end
                    if (got.id !== want.id) begin
                        $error("out_id mismatch: expected %0d, got %0d", want.id, got.id);
                        mismatches++;
                    end
                    if (got.score !== want.score) begin
                        $error("out_score mismatch: expected %0d, got %0d",
                               want.score, got.score);
                        mismatches++;
                    end
                    if (got.rem !== want.rem) begin
                        $error("remaining mismatch: expected %0d, got %0d", want.rem, got.rem);
                        mismatches++;
                    end
                    if (got.last !== want.last) begin
                        $error("last mismatch: expected %0d, got %0d", want.last, got.last);
                        mismatches++;
                    end
                end
                if ($urandom_range(0, 11) == 0)
                    mon_no_idle = !mon_no_idle;
                mon_wait = draw_wait(mon_no_idle);
            end else if (mon_wait > 0) begin
                mon_wait--;
            end
            i_m_axis_tready <= (mon_wait == 0);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // stimulus sequence
    initial begin
        int dir_scores[16];
        logic [11:0] thr_plan[5];
        t_cmd_beat b;
        int counted;
        int enq_pct;
        int purge_pct;

        dir_scores = '{0, 2499, 2500, 2501, 3100, 4095, 1, 4094,
                       2048, 2047, 1250, 3000, 2499, 0, 2600, 100};
        thr_plan = '{12'd0, 12'd3100, 12'd4095, 12'($urandom_range(0, 3100)),
                     12'($urandom_range(1000, 2800))};

        // directed: empty queue, fill to full, overflow, ignored code, purges, dequeues
        cmd_backlog.push_back('{CMD_DEQ, 31'h7fff_ffff, 12'hfff});
        cmd_backlog.push_back('{CMD_PURGE, 31'h0, 12'h0});
        for (int i = 0; i < DEPTH; i++) begin
            case (i)
                0: b.id = 31'h7fff_ffff;
                1: b.id = 31'h0;
                2: b.id = 31'h2aaa_aaaa;
                3: b.id = 31'h5555_5555;
                default: b.id = ID_W'($urandom);
            endcase
            cmd_backlog.push_back('{CMD_ENQ, b.id, SCORE_W'(dir_scores[i])});
        end
        cmd_backlog.push_back('{CMD_ENQ, 31'h1234_5678, 12'd10});
        cmd_backlog.push_back('{CMD_NOP, 31'h7fff_ffff, 12'hfff});
        cmd_backlog.push_back('{CMD_PURGE, 31'h7fff_ffff, 12'hfff});
        cmd_backlog.push_back('{CMD_PURGE, 31'h0, 12'h0});
        cmd_backlog.push_back('{CMD_DEQ, 31'h0, 12'h0});
        cmd_backlog.push_back('{CMD_DEQ, 31'h0, 12'h0});

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // random phases, each under its own threshold
        for (int p = 0; p < 5; p++) begin
            do @(negedge i_clk);
            while (cmd_backlog.size() != 0 || i_s_axis_tvalid || expected_results.size() != 0);
            repeat (SETTLE_CYCLES) @(posedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_wdata <= thr_plan[p];
            shadow_thr = thr_plan[p];
            @(posedge i_clk);
            i_cfg_we <= 1'b0;

            enq_pct = $urandom_range(40, 70);
            purge_pct = $urandom_range(8, 18);
            counted = 0;
            while (counted < PHASE_BEATS) begin
                b = random_command(enq_pct, purge_pct);
                if (b.cmd != CMD_NOP)
                    counted++;
                cmd_backlog.push_back(b);
            end
        end

        // drain and settle
        do @(negedge i_clk);
        while (cmd_backlog.size() != 0 || i_s_axis_tvalid || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
